// ===== rtl/ldsv_pkg.sv =====
// Shared types and codes for the linear Diophantine solver.
`default_nettype none

package ldsv_pkg;

	// Result status codes
	localparam logic [1:0] ST_ONE  = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_INF  = 2'd2;

	// Input item: a*x + b*y = c
	typedef struct packed {
		logic signed [31:0] a_coef;
		logic signed [31:0] b_coef;
		logic signed [31:0] c_value;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic        [1:0]  status;
		logic        [31:0] gcd_value;
		logic signed [63:0] x_solution;
		logic signed [63:0] y_solution;
	} out_item_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/ldsv_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module ldsv_div #(
	parameter int WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [WIDTH-1:0]    dividend,
	input  wire logic [WIDTH-1:0]    divisor,
	output ldsv_pkg::div_stat_t      stat,
	output logic      [WIDTH-1:0]    quotient,
	output logic      [WIDTH-1:0]    remainder
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] dq_q;
	logic [WIDTH-1:0] dv_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   rem_diff;
	logic             fits;

	// Shift in the next dividend bit and trial-subtract the divisor
	always_comb begin
		rem_sh   = {rem_q, dq_q[WIDTH-1]};
		rem_diff = rem_sh - {1'b0, dv_q};
		fits     = (rem_sh >= {1'b0, dv_q});
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
			dq_q  <= {dq_q[WIDTH-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== rtl/ldsv_mul.sv =====
// Unsigned multiplier with a registered product.
`default_nettype none

module ldsv_mul #(
	parameter int WIDTH = 32
) (
	input  wire logic               clk,
	input  wire logic [WIDTH-1:0]   op_a,
	input  wire logic [WIDTH-1:0]   op_b,
	output logic      [2*WIDTH-1:0] prod
);

	logic [2*WIDTH-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= (2*WIDTH)'(op_a) * (2*WIDTH)'(op_b);
	end

	assign prod = prod_q;

endmodule

`default_nettype wire

// ===== rtl/linear_diophantine_solver.sv =====
// Top level: sequencer around a shared divider and multiplier.
`default_nettype none

// Solves a*x + b*y = c for one particular integer pair. Each field is taken
// as its low WIDTH bits, sign-extended. The extended Euclidean algorithm runs
// on |a| and |b|. Every Euclid step uses the bit-serial divider for the
// quotient, then the shared multiplier twice to update the Bezout
// coefficients. A final division of |c| by the gcd and two multiplies give x
// and y; the multiplies are skipped when the gcd does not divide c. At
// WIDTH=32 there are at most 45 Euclid steps. When both coefficients are zero
// the sequencer goes from idle straight to the done state.
// in_ready is high only while no item is in work. It comes back in the same
// cycle that the result appears in the output register. A finished result
// waits in the output register, and the next item may be accepted meanwhile.
// A second finished result waits until the receiver takes the first one, and
// in_ready stays low during that wait.
module linear_diophantine_solver #(
	parameter int WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire ldsv_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output ldsv_pkg::out_item_t       out_item
);

	typedef enum logic [3:0] {
		S_IDLE, S_LOOP, S_DIV, S_MULS, S_MULT, S_UPD,
		S_FDIV, S_MULX, S_MULY, S_FINY, S_DONE
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	ldsv_pkg::out_item_t out_item_q;

	// Euclid working registers; s and t are two's complement in WIDTH+1 bits
	logic [WIDTH-1:0] r0_q, r1_q, rn_q, q_q, k_q, c_mag_q, g_q;
	logic [WIDTH:0]   s0_q, s1_q, t0_q, t1_q;
	logic             a_neg_q, b_neg_q, c_neg_q;
	logic [1:0]       status_q;
	logic [63:0]      x_q, y_q;

	// Input decode
	logic [WIDTH-1:0] a_w, b_w, c_w, a_mag, b_mag, c_mag;
	logic [WIDTH-1:0] one_w;
	logic             in_acc;

	assign one_w = {{(WIDTH-1){1'b0}}, 1'b1};
	assign a_w   = in_item.a_coef[WIDTH-1:0];
	assign b_w   = in_item.b_coef[WIDTH-1:0];
	assign c_w   = in_item.c_value[WIDTH-1:0];
	assign a_mag = a_w[WIDTH-1] ? (~a_w + one_w) : a_w;
	assign b_mag = b_w[WIDTH-1] ? (~b_w + one_w) : b_w;
	assign c_mag = c_w[WIDTH-1] ? (~c_w + one_w) : c_w;
	assign in_acc = in_valid && in_ready;

	// Magnitudes of the coefficient registers
	logic [WIDTH:0]   one_s;
	logic [WIDTH:0]   s0_abs, s1_abs, t0_abs, t1_abs;

	assign one_s  = {{WIDTH{1'b0}}, 1'b1};
	assign s0_abs = s0_q[WIDTH] ? (~s0_q + one_s) : s0_q;
	assign s1_abs = s1_q[WIDTH] ? (~s1_q + one_s) : s1_q;
	assign t0_abs = t0_q[WIDTH] ? (~t0_q + one_s) : t0_q;
	assign t1_abs = t1_q[WIDTH] ? (~t1_q + one_s) : t1_q;

	// Shared divider
	logic                div_start;
	logic [WIDTH-1:0]    div_num, div_den, div_quo, div_rem;
	ldsv_pkg::div_stat_t div_stat;

	assign div_start = (state_q == S_LOOP);
	assign div_num   = (r1_q == '0) ? c_mag_q : r0_q;
	assign div_den   = (r1_q == '0) ? r0_q : r1_q;

	ldsv_div #(.WIDTH(WIDTH)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (div_den),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Shared multiplier, operands picked by the sequencer state
	logic [WIDTH-1:0]   mul_a, mul_b;
	logic [2*WIDTH-1:0] mul_p;
	logic [WIDTH:0]     p_low;
	logic [63:0]        p64;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MULS: begin
				mul_a = q_q;
				mul_b = s1_abs[WIDTH-1:0];
			end
			S_MULT: begin
				mul_a = q_q;
				mul_b = t1_abs[WIDTH-1:0];
			end
			S_MULX: begin
				mul_a = k_q;
				mul_b = s0_abs[WIDTH-1:0];
			end
			S_MULY: begin
				mul_a = k_q;
				mul_b = t0_abs[WIDTH-1:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	ldsv_mul #(.WIDTH(WIDTH)) u_mul (
		.clk  (clk),
		.op_a (mul_a),
		.op_b (mul_b),
		.prod (mul_p)
	);

	assign p_low = mul_p[WIDTH:0];
	assign p64   = 64'(mul_p);

	// A finished result moves out once the output register is free
	logic out_load;

	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_item_q  <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						state_q <= (a_w == '0 && b_w == '0) ? S_DONE : S_LOOP;
					end
				end
				S_LOOP: begin
					state_q <= (r1_q == '0) ? S_FDIV : S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_MULS;
					end
				end
				S_MULS: state_q <= S_MULT;
				S_MULT: state_q <= S_UPD;
				S_UPD:  state_q <= S_LOOP;
				S_FDIV: begin
					if (div_stat.done) begin
						state_q <= (div_rem != '0) ? S_DONE : S_MULX;
					end
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: state_q <= S_FINY;
				S_FINY: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						out_item_q.status     <= status_q;
						out_item_q.gcd_value  <= 32'(g_q);
						out_item_q.x_solution <= x_q;
						out_item_q.y_solution <= y_q;
						state_q               <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Euclid datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					a_neg_q  <= a_w[WIDTH-1];
					b_neg_q  <= b_w[WIDTH-1];
					c_neg_q  <= c_w[WIDTH-1];
					c_mag_q  <= c_mag;
					r0_q     <= a_mag;
					r1_q     <= b_mag;
					s0_q     <= one_s;
					s1_q     <= '0;
					t0_q     <= '0;
					t1_q     <= one_s;
					g_q      <= '0;
					x_q      <= '0;
					y_q      <= '0;
					status_q <= (a_w == '0 && b_w == '0 && c_w == '0) ?
						ldsv_pkg::ST_INF : ldsv_pkg::ST_NONE;
				end
			end
			S_LOOP: begin
				if (r1_q == '0) begin
					g_q <= r0_q;
				end
			end
			S_DIV: begin
				if (div_stat.done) begin
					q_q  <= div_quo;
					rn_q <= div_rem;
				end
			end
			// product is q*|s1|
			S_MULT: begin
				s0_q <= s1_q;
				s1_q <= s1_q[WIDTH] ? (s0_q + p_low) : (s0_q - p_low);
			end
			// product is q*|t1|
			S_UPD: begin
				t0_q <= t1_q;
				t1_q <= t1_q[WIDTH] ? (t0_q + p_low) : (t0_q - p_low);
				r0_q <= r1_q;
				r1_q <= rn_q;
			end
			S_FDIV: begin
				if (div_stat.done) begin
					k_q <= div_quo;
					status_q <= (div_rem != '0) ? ldsv_pkg::ST_NONE : ldsv_pkg::ST_ONE;
				end
			end
			// product is |s0|*|c/g|
			S_MULY: begin
				x_q <= (s0_q[WIDTH] ^ c_neg_q ^ a_neg_q) ? (64'(0) - p64) : p64;
			end
			// product is |t0|*|c/g|
			S_FINY: begin
				y_q <= (t0_q[WIDTH] ^ c_neg_q ^ b_neg_q) ? (64'(0) - p64) : p64;
			end
			default: begin
			end
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Only the one-solution status carries a nonzero pair
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status != ldsv_pkg::ST_ONE) |->
		(out_item.x_solution == 64'(0) && out_item.y_solution == 64'(0)))
		else $error("nonzero solution with status other than one solution");

	// Infinite solutions only arise with a zero gcd
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.status == ldsv_pkg::ST_INF) |->
		(out_item.gcd_value == 32'(0)))
		else $error("infinite status with nonzero gcd");

	// The divider is never restarted while it is working
	assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider started while busy");

	// An accepted item keeps the block busy for the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("ready right after an accepted item");

endmodule

`default_nettype wire
